@@ rtl/core/scn_pkg.sv @@
`default_nettype none

package scn_pkg;

  // Input command codes.
  localparam logic [1:0] CMD_DEC_BYTE  = 2'd0;
  localparam logic [1:0] CMD_DEC_EMPTY = 2'd1;
  localparam logic [1:0] CMD_ENCODE    = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_NONMINIMAL = 2'd2;

  // Result kinds.
  localparam logic KIND_DEC = 1'b0;
  localparam logic KIND_ENC = 1'b1;

  // Configuration register indexes.
  localparam logic REG_MAX_SIZE = 1'b0;
  localparam logic REG_REQ_MIN  = 1'b1;

  localparam logic [3:0] MAX_SIZE_RESET = 4'd4;
  localparam logic       REQ_MIN_RESET  = 1'b1;
  localparam logic [3:0] COUNT_SAT      = 4'd15;

  // Which result the output register takes this cycle.
  typedef enum logic [2:0] {
    LD_NONE,
    LD_DEC,
    LD_DEC_ZERO,
    LD_ENC_BYTE,
    LD_ENC_EXTRA,
    LD_ENC_EMPTY
  } load_sel_t;

  typedef struct packed {
    logic      take;
    load_sel_t load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic can_load;
    logic mag_zero;
    logic rest_zero;
    logic top_bit;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/core/scn_ctrl.sv @@
`default_nettype none

module scn_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic [1:0]         in_cmd,
  input  wire logic               in_last,
  input  wire scn_pkg::dp_status_t sts,
  output scn_pkg::ctrl_cmd_t      ctl,
  output logic                    in_stall
);

  typedef enum logic [2:0] {
    IDLE,
    DEC_FIN,
    DEC_EMPTY,
    ENC_RUN,
    ENC_EXTRA
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != IDLE);

  always_comb begin
    state_next = state;
    ctl.take   = in_valid && (state == IDLE);
    ctl.load   = scn_pkg::LD_NONE;
    case (state)
      IDLE: begin
        if (ctl.take) begin
          case (in_cmd)
            scn_pkg::CMD_DEC_BYTE: begin
              if (in_last) state_next = DEC_FIN;
            end
            scn_pkg::CMD_DEC_EMPTY: state_next = DEC_EMPTY;
            scn_pkg::CMD_ENCODE:    state_next = ENC_RUN;
            default:                state_next = IDLE;
          endcase
        end
      end
      DEC_FIN: begin
        if (sts.can_load) begin
          ctl.load   = scn_pkg::LD_DEC;
          state_next = IDLE;
        end
      end
      DEC_EMPTY: begin
        if (sts.can_load) begin
          ctl.load   = scn_pkg::LD_DEC_ZERO;
          state_next = IDLE;
        end
      end
      ENC_RUN: begin
        if (sts.can_load) begin
          if (sts.mag_zero) begin
            ctl.load   = scn_pkg::LD_ENC_EMPTY;
            state_next = IDLE;
          end else begin
            ctl.load = scn_pkg::LD_ENC_BYTE;
            if (sts.rest_zero) state_next = sts.top_bit ? ENC_EXTRA : IDLE;
          end
        end
      end
      ENC_EXTRA: begin
        if (sts.can_load) begin
          ctl.load   = scn_pkg::LD_ENC_EXTRA;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/scn_dp.sv @@
`default_nettype none

module scn_dp #(
  parameter int VALUE_BYTES = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire scn_pkg::ctrl_cmd_t ctl,
  output scn_pkg::dp_status_t     sts,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_index,
  input  wire logic [3:0]         cfg_data,
  input  wire logic [1:0]         cmd,
  input  wire logic [7:0]         data_byte,
  input  wire logic               last_in,
  input  wire logic [63:0]        value_in,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output logic                    kind,
  output logic [63:0]             value_out,
  output logic [31:0]             value_sat32,
  output logic [1:0]              status,
  output logic [7:0]              out_byte,
  output logic                    byte_valid,
  output logic                    last_out
);

  localparam int ACC_W = VALUE_BYTES * 8;

  logic [3:0]       max_size;
  logic             req_min;
  logic [ACC_W-1:0] acc, acc_next;
  logic [3:0]       cnt, cnt_inc;
  logic [7:0]       prev;
  logic [7:0]       last_byte;
  logic [63:0]      mag;
  logic             neg;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_size <= scn_pkg::MAX_SIZE_RESET;
      req_min  <= scn_pkg::REQ_MIN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        scn_pkg::REG_MAX_SIZE: max_size <= cfg_data;
        scn_pkg::REG_REQ_MIN:  req_min  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Merge the incoming byte into its lane; bytes past the last lane are dropped.
  always_comb begin
    acc_next = acc;
    for (int i = 0; i < VALUE_BYTES; i++) begin
      if (cnt == 4'(i)) acc_next[i*8 +: 8] = acc[i*8 +: 8] | data_byte;
    end
  end

  assign cnt_inc = (cnt == scn_pkg::COUNT_SAT) ? scn_pkg::COUNT_SAT : cnt + 4'd1;

  // Final decode evaluation from the stored run.
  logic [3:0]       limit;
  logic [ACC_W-1:0] dec_mag;
  logic [63:0]      dec_mag64, dec_val, dec_res;
  logic [1:0]       dec_status;
  logic [31:0]      dec_sat;

  assign limit = (max_size < 4'(VALUE_BYTES)) ? max_size : 4'(VALUE_BYTES);

  always_comb begin
    dec_mag = acc;
    for (int i = 0; i < VALUE_BYTES; i++) begin
      if (cnt == 4'(i + 1)) dec_mag[i*8 + 7] = 1'b0;
    end
    dec_mag64 = 64'(dec_mag);
    dec_val   = last_byte[7] ? (64'd0 - dec_mag64) : dec_mag64;
    if (cnt > limit) begin
      dec_status = scn_pkg::ST_OVERFLOW;
    end else if (req_min && (last_byte[6:0] == 7'd0) && ((cnt <= 4'd1) || !prev[7])) begin
      dec_status = scn_pkg::ST_NONMINIMAL;
    end else begin
      dec_status = scn_pkg::ST_OK;
    end
    dec_res = (dec_status == scn_pkg::ST_OK) ? dec_val : 64'd0;
    if (dec_res[63] && !(&dec_res[63:31])) begin
      dec_sat = 32'h8000_0000;
    end else if (!dec_res[63] && (|dec_res[63:31])) begin
      dec_sat = 32'h7fff_ffff;
    end else begin
      dec_sat = dec_res[31:0];
    end
  end

  // Decode run state and encode magnitude shifter.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      cnt  <= '0;
      prev <= '0;
    end else if (ctl.take && (cmd == scn_pkg::CMD_DEC_BYTE)) begin
      acc <= acc_next;
      cnt <= cnt_inc;
      if (!last_in) prev <= data_byte;
    end else if ((ctl.take && (cmd == scn_pkg::CMD_DEC_EMPTY)) ||
                 (ctl.load == scn_pkg::LD_DEC)) begin
      acc  <= '0;
      cnt  <= '0;
      prev <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take && (cmd == scn_pkg::CMD_DEC_BYTE)) last_byte <= data_byte;
    if (ctl.take && (cmd == scn_pkg::CMD_ENCODE)) begin
      neg <= value_in[63];
      mag <= value_in[63] ? (64'd0 - value_in) : value_in;
    end else if (ctl.load == scn_pkg::LD_ENC_BYTE) begin
      mag <= mag >> 8;
    end
  end

  assign sts.can_load  = !out_valid || !out_stall;
  assign sts.mag_zero  = (mag == 64'd0);
  assign sts.rest_zero = (mag[63:8] == 56'd0);
  assign sts.top_bit   = mag[7];

  // Output register.
  logic        kind_next;
  logic [63:0] value_out_next;
  logic [31:0] value_sat32_next;
  logic [1:0]  status_next;
  logic [7:0]  out_byte_next;
  logic        byte_valid_next;
  logic        last_out_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load != scn_pkg::LD_NONE) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    kind_next        = scn_pkg::KIND_ENC;
    value_out_next   = 64'd0;
    value_sat32_next = 32'd0;
    status_next      = scn_pkg::ST_OK;
    out_byte_next    = 8'd0;
    byte_valid_next  = 1'b0;
    last_out_next    = 1'b1;
    case (ctl.load)
      scn_pkg::LD_DEC: begin
        kind_next        = scn_pkg::KIND_DEC;
        value_out_next   = dec_res;
        value_sat32_next = dec_sat;
        status_next      = dec_status;
      end
      scn_pkg::LD_DEC_ZERO: kind_next = scn_pkg::KIND_DEC;
      scn_pkg::LD_ENC_BYTE: begin
        byte_valid_next = 1'b1;
        if (sts.rest_zero && !mag[7]) begin
          out_byte_next = {neg, mag[6:0]};
        end else begin
          out_byte_next = mag[7:0];
          last_out_next = 1'b0;
        end
      end
      scn_pkg::LD_ENC_EXTRA: begin
        byte_valid_next = 1'b1;
        out_byte_next   = {neg, 7'd0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load != scn_pkg::LD_NONE) begin
      kind        <= kind_next;
      value_out   <= value_out_next;
      value_sat32 <= value_sat32_next;
      status      <= status_next;
      out_byte    <= out_byte_next;
      byte_valid  <= byte_valid_next;
      last_out    <= last_out_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/script_number_codec_top.sv @@
`default_nettype none

// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   cmd, data_byte, last_in, value_in
// out       output     out_valid / out_stall kind, value_out, value_sat32, status,
//                                            out_byte, byte_valid, last_out
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A decode byte that is not the last one is taken while the controller stays idle, so
// the next byte can follow without a wait. The last byte is gathered, then evaluated
// for length, minimality, sign and saturation into the output register once that can
// load. An encode captures the magnitude, then emits up to nine bytes from the single
// byte-serial shifter as the output register can load; the input stalls meanwhile.
// Reset (synchronous, rst high) restores max_size 4 and require_minimal 1 and clears
// the open number. A stalled result holds in the output register and the block waits.
//
// The design is split into a controller state machine (scn_ctrl) that sequences each
// transaction and a datapath (scn_dp) that holds the decode accumulator, the encode
// shifter, the configuration registers and the output register. The output register
// decouples the two sides, so a new input transaction is taken while a finished result
// still waits, as long as the controller is idle.

module script_number_codec_top #(
  parameter int VALUE_BYTES = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // Input channel.
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         cmd,
  input  wire logic [7:0]         data_byte,
  input  wire logic               last_in,
  input  wire logic signed [63:0] value_in,
  // Output channel.
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    kind,
  output logic signed [63:0]      value_out,
  output logic signed [31:0]      value_sat32,
  output logic [1:0]              status,
  output logic [7:0]              out_byte,
  output logic                    byte_valid,
  output logic                    last_out,
  // Configuration channel. Writes are always accepted.
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [3:0]         cfg_data
);

  scn_pkg::ctrl_cmd_t  ctl;
  scn_pkg::dp_status_t sts;

  assign cfg_ready = 1'b1;

  // The controller only decides when a transaction is taken and which result the
  // output register loads; all arithmetic lives in the datapath.
  scn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cmd   (cmd),
    .in_last  (last_in),
    .sts      (sts),
    .ctl      (ctl),
    .in_stall (in_stall)
  );

  scn_dp #(
    .VALUE_BYTES (VALUE_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .data_byte   (data_byte),
    .last_in     (last_in),
    .value_in    (value_in),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .kind        (kind),
    .value_out   (value_out),
    .value_sat32 (value_sat32),
    .status      (status),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .last_out    (last_out)
  );

endmodule

`default_nettype wire

@@ rtl/core/scn_checker.sv @@
`default_nettype none

module scn_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        kind,
  input wire logic [63:0] value_out,
  input wire logic [31:0] value_sat32,
  input wire logic [1:0]  status,
  input wire logic [7:0]  out_byte,
  input wire logic        byte_valid,
  input wire logic        last_out
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(value_out)
                               && $stable(last_out))
    else $error("stalled result changed");

  // A decode result is always a whole run of its own and carries no byte.
  a_dec_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == scn_pkg::KIND_DEC) |-> last_out && !byte_valid && (out_byte == 8'd0))
    else $error("malformed decode result");

  // A failed decode reports zero in both value fields.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != scn_pkg::ST_OK) |-> (value_out == 64'd0) && (value_sat32 == 32'd0))
    else $error("error result carries a value");

  // The empty encoding is a single final result.
  a_enc_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == scn_pkg::KIND_ENC) && !byte_valid |-> last_out && (out_byte == 8'd0))
    else $error("empty encoding not final");

endmodule

bind script_number_codec_top scn_checker u_scn_checker (.*);

`default_nettype wire

@@ dv/script_number_codec_top_test.sv @@
`timescale 1ns / 1ps

module script_number_codec_top_test;

  // The package names the three commands the block acts on; the fourth code is a no-op.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int NUMBER_BYTES = 8;
  // Cycles to let pass after the last expected transaction before touching the
  // registers or ending the run. The slowest job is a nine-byte encode.
  localparam int DRAIN_CYCLES = 16;
  // Length of the long receiver hold-off that backs the block up into its input.
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 48;

  typedef struct packed {
    logic               kind;
    logic signed [63:0] value;
    logic signed [31:0] sat;
    logic [1:0]         status;
    logic [7:0]         octet;
    logic               octet_valid;
    logic               last;
  } codec_result_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [7:0]         data_byte;
    logic               last;
    logic signed [63:0] value;
  } codec_item_t;

  // One row of the directed table. When typed is set, the row carries its own
  // expected transaction; otherwise the predictor supplies it.
  typedef struct packed {
    codec_item_t   item;
    logic          typed;
    codec_result_t want;
  } stimulus_row_t;

  localparam codec_result_t NOT_TYPED = '0;
  localparam codec_result_t EMPTY_ENCODING =
    {scn_pkg::KIND_ENC, 64'd0, 32'd0, scn_pkg::ST_OK, 8'd0, 1'b0, 1'b1};

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         cmd;
  logic [7:0]         data_byte;
  logic               last_in;
  logic signed [63:0] value_in;
  logic               out_valid;
  logic               out_stall;
  logic               kind;
  logic signed [63:0] value_out;
  logic signed [31:0] value_sat32;
  logic [1:0]         status;
  logic [7:0]         out_byte;
  logic               byte_valid;
  logic               last_out;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index;
  logic [3:0]         cfg_data;

  script_number_codec_top #(
    .VALUE_BYTES(NUMBER_BYTES)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .data_byte  (data_byte),
    .last_in    (last_in),
    .value_in   (value_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .value_out  (value_out),
    .value_sat32(value_sat32),
    .status     (status),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .last_out   (last_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Our own copy of the block's registers and of the number being gathered.
  logic [3:0]  max_size_setting;
  logic        minimal_required;
  logic [63:0] open_value;
  logic [3:0]  open_count;
  logic [7:0]  open_prev_byte;

  // Output transactions that the block still owes, oldest first.
  codec_result_t number_results_due[$];

  int  mismatch_count;
  int  offered_items;
  bit  hold_request;
  bit  calm;

  stimulus_row_t directed_rows[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Appends one output transaction to the list still owed.
  function automatic void owe_result(input codec_result_t r);
    number_results_due.insert(number_results_due.size(), r);
  endfunction

  // Appends one row to the directed table.
  function automatic void add_row(input stimulus_row_t row);
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Builds a decode transaction. The 32-bit copy saturates at the int32 bounds.
  function automatic codec_result_t decoded(input logic signed [63:0] v,
                                            input logic [1:0] st);
    codec_result_t r;
    r        = '0;
    r.kind   = scn_pkg::KIND_DEC;
    r.value  = v;
    r.status = st;
    r.last   = 1'b1;
    if (v < -64'sd2147483648) begin
      r.sat = 32'h8000_0000;
    end else if (v > 64'sd2147483647) begin
      r.sat = 32'h7fff_ffff;
    end else begin
      r.sat = v[31:0];
    end
    return r;
  endfunction

  // Minimal sign-magnitude byte string of a value, least significant byte in
  // octets[7:0]. Zero gives an empty string.
  function automatic void minimal_bytes(input logic signed [63:0] v,
                                        output logic [71:0] octets,
                                        output int count);
    logic [63:0] mag;
    logic        neg;
    neg    = v[63];
    mag    = neg ? -v : v;
    octets = '0;
    count  = 0;
    while (mag != 0) begin
      octets[8*count +: 8] = mag[7:0];
      mag = mag >> 8;
      count++;
    end
    if (count > 0) begin
      // A magnitude whose top bit collides with the sign bit needs one more byte.
      if (octets[8*count-1]) begin
        octets[8*count +: 8] = neg ? 8'h80 : 8'h00;
        count++;
      end else if (neg) begin
        octets[8*count-1] = 1'b1;
      end
    end
  endfunction

  // Applies one accepted input transaction to the predicted state and queues
  // the output transactions it causes.
  function automatic void script_number_apply(input codec_item_t it);
    logic [3:0]         next_count;
    logic [3:0]         limit;
    logic [1:0]         st;
    logic signed [63:0] val;
    logic [71:0]        octets;
    int                 n;
    codec_result_t      r;
    case (it.cmd)
      scn_pkg::CMD_DEC_BYTE: begin
        // Bytes past the value width are counted but not gathered.
        if (open_count < 4'(NUMBER_BYTES)) begin
          open_value = open_value | ({56'd0, it.data_byte} << (8 * int'(open_count)));
        end
        next_count = (open_count == scn_pkg::COUNT_SAT) ? scn_pkg::COUNT_SAT
                                                        : open_count + 4'd1;
        if (!it.last) begin
          open_count     = next_count;
          open_prev_byte = it.data_byte;
        end else begin
          limit = (max_size_setting < 4'(NUMBER_BYTES)) ? max_size_setting
                                                          : 4'(NUMBER_BYTES);
          st  = scn_pkg::ST_OK;
          val = '0;
          // Overflow wins over a non-minimal encoding.
          if (next_count > limit) begin
            st = scn_pkg::ST_OVERFLOW;
          end else if (minimal_required && it.data_byte[6:0] == 7'd0 &&
                       (next_count <= 4'd1 || !open_prev_byte[7])) begin
            st = scn_pkg::ST_NONMINIMAL;
          end else begin
            val = open_value;
            if (it.data_byte[7]) begin
              val = -(val & ~(64'h80 << (8 * (int'(next_count) - 1))));
            end
          end
          open_value     = '0;
          open_count     = '0;
          open_prev_byte = '0;
          owe_result(decoded(val, st));
        end
      end
      scn_pkg::CMD_DEC_EMPTY: begin
        // An empty number also abandons whatever was being gathered.
        open_value     = '0;
        open_count     = '0;
        open_prev_byte = '0;
        owe_result(decoded(64'sd0, scn_pkg::ST_OK));
      end
      scn_pkg::CMD_ENCODE: begin
        // Encoding leaves an open decode untouched.
        if (it.value == 0) begin
          owe_result(EMPTY_ENCODING);
        end else begin
          minimal_bytes(it.value, octets, n);
          for (int k = 0; k < n; k++) begin
            r             = '0;
            r.kind        = scn_pkg::KIND_ENC;
            r.octet       = octets[8*k +: 8];
            r.octet_valid = 1'b1;
            r.last        = (k == n - 1);
            owe_result(r);
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Random signed value spread over all byte lengths, with the extremes and the
  // int32 saturation edges showing up now and then.
  function automatic logic signed [63:0] random_number();
    logic signed [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 15))
      0:       r = 64'sh8000_0000_0000_0000;
      1:       r = 64'sh7fff_ffff_ffff_ffff;
      2:       r = 64'sd0;
      3:       r = 64'sd2147483647 + $urandom_range(0, 1);
      4:       r = -64'sd2147483648 - $urandom_range(0, 1);
      default: r = r >>> $urandom_range(0, 63);
    endcase
    return r;
  endfunction

  // Offers one input transaction and waits until the block takes it. Returns
  // just after the accepting rising edge; in_valid is left as it was, and the
  // next driver step lowers or reuses it at the following falling edge.
  task automatic offer(input logic [1:0] c, input logic [7:0] b, input logic l,
                       input logic signed [63:0] v, input logic typed = 1'b0,
                       input codec_result_t want = NOT_TYPED);
    codec_item_t it;
    it = {c, b, l, v};
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    data_byte <= b;
    last_in   <= l;
    value_in  <= v;
    do @(posedge clk); while (in_stall);
    offered_items++;
    script_number_apply(it);
    // A typed row replaces the prediction with the value written in the table.
    if (typed) begin
      number_results_due[number_results_due.size() - 1] = want;
    end
  endtask

  // Lowers the input valid and lets the block run dry before a register write.
  task automatic write_register(input logic idx, input logic [3:0] data);
    @(negedge clk);
    in_valid <= 1'b0;
    while (number_results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == scn_pkg::REG_MAX_SIZE) begin
      max_size_setting = data;
    end else begin
      minimal_required = data[0];
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One random sequence: mostly well-formed numbers and encodes with random
  // content, plus raw byte runs and the odd stray command.
  task automatic random_group();
    logic signed [63:0] v;
    logic [71:0]        octets;
    logic [7:0]         b;
    int                 n;
    int                 len;
    int                 pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      v = random_number();
      minimal_bytes(v, octets, n);
      // Sometimes pad the number with a redundant top byte, while it still fits.
      if (n < 9 && $urandom_range(0, 4) == 0) begin
        octets[8*n +: 8] = $urandom_range(0, 1) ? 8'h80 : 8'h00;
        n++;
      end
      if (n == 0) begin
        offer(scn_pkg::CMD_DEC_EMPTY, 8'($urandom), 1'($urandom), {$urandom, $urandom});
      end else begin
        for (int k = 0; k < n; k++) begin
          offer(scn_pkg::CMD_DEC_BYTE, octets[8*k +: 8], k == n - 1,
                {$urandom, $urandom});
        end
      end
    end else if (pick < 70) begin
      offer(scn_pkg::CMD_ENCODE, 8'($urandom), 1'($urandom), random_number());
    end else if (pick < 88) begin
      // Raw byte run, up to past the value width, with a sign-only top byte often.
      len = $urandom_range(1, 10);
      for (int k = 0; k < len; k++) begin
        b = 8'($urandom);
        if (k == len - 1 && $urandom_range(0, 1) == 0) begin
          b = $urandom_range(0, 1) ? 8'h80 : 8'h00;
        end else if ($urandom_range(0, 5) == 0) begin
          b = 8'h80;
        end
        offer(scn_pkg::CMD_DEC_BYTE, b, k == len - 1, {$urandom, $urandom});
      end
    end else begin
      case ($urandom_range(0, 2))
        0: offer(CMD_UNUSED, 8'($urandom), 1'($urandom), {$urandom, $urandom});
        1: offer(scn_pkg::CMD_DEC_EMPTY, 8'($urandom), 1'($urandom),
                 {$urandom, $urandom});
        default: begin
          // An unfinished byte, then an encode in the middle of the number.
          offer(scn_pkg::CMD_DEC_BYTE, 8'($urandom), 1'b0, {$urandom, $urandom});
          offer(scn_pkg::CMD_ENCODE, 8'($urandom), 1'($urandom), random_number());
        end
      endcase
    end
  endtask

  // Receiver side: random stall bursts, plus one long hold-off on request so the
  // block fills up and pushes back on its input.
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(1, 12) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Each output transaction is compared against the oldest one still owed.
  always @(posedge clk) begin
    codec_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (number_results_due.size() == 0) begin
        $error("unexpected output transaction: kind %0d value %0d byte %02h",
               kind, value_out, out_byte);
        mismatch_count++;
      end else begin
        want = number_results_due.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind);
          mismatch_count++;
        end
        if (value_out !== want.value) begin
          $error("value_out: expected %0d, got %0d", want.value, value_out);
          mismatch_count++;
        end
        if (value_sat32 !== want.sat) begin
          $error("value_sat32: expected %0d, got %0d", want.sat, value_sat32);
          mismatch_count++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatch_count++;
        end
        if (out_byte !== want.octet) begin
          $error("out_byte: expected %02h, got %02h", want.octet, out_byte);
          mismatch_count++;
        end
        if (byte_valid !== want.octet_valid) begin
          $error("byte_valid: expected %0d, got %0d", want.octet_valid, byte_valid);
          mismatch_count++;
        end
        if (last_out !== want.last) begin
          $error("last_out: expected %0d, got %0d", want.last, last_out);
          mismatch_count++;
        end
      end
    end
  end

  // Generous ceiling: every item at nine bytes, each byte behind the longest
  // stall burst, plus the hold-off and the drains around the register writes.
  initial begin
    #3_000_000;
    $display("script_number_codec_top_test: FAIL");
    $finish;
  end

  initial begin
    logic [3:0] phase_size;
    logic       phase_minimal;
    int         phase_start;

    mismatch_count = 0;
    offered_items  = 0;
    hold_request   = 1'b0;
    calm           = 1'b0;

    rst       = 1'b1;
    in_valid  = 1'b0;
    cmd       = scn_pkg::CMD_DEC_BYTE;
    data_byte = 8'h00;
    last_in   = 1'b0;
    value_in  = 64'sd0;
    cfg_valid = 1'b0;
    cfg_index = scn_pkg::REG_MAX_SIZE;
    cfg_data  = 4'd0;

    max_size_setting = scn_pkg::MAX_SIZE_RESET;
    minimal_required = scn_pkg::REQ_MIN_RESET;
    open_value       = '0;
    open_count       = '0;
    open_prev_byte   = '0;

    // Directed table, run with the reset settings: limit four bytes and minimal
    // encoding required.
    // Empty number, then a lone zero byte, which is not minimal.
    add_row({scn_pkg::CMD_DEC_EMPTY, 8'h00, 1'b1, 64'sd0, 1'b1,
             decoded(64'sd0, scn_pkg::ST_OK)});
    add_row({scn_pkg::CMD_DEC_BYTE, 8'h00, 1'b1, 64'sd0, 1'b1,
             decoded(64'sd0, scn_pkg::ST_NONMINIMAL)});
    add_row({scn_pkg::CMD_DEC_BYTE, 8'h81, 1'b1, 64'sd0, 1'b1,
             decoded(-64'sd1, scn_pkg::ST_OK)});
    // Largest positive four-byte number.
    add_row({scn_pkg::CMD_DEC_BYTE, 8'hff, 1'b0, 64'sd0, 1'b0, NOT_TYPED});
    add_row({scn_pkg::CMD_DEC_BYTE, 8'hff, 1'b0, 64'sd0, 1'b0, NOT_TYPED});
    add_row({scn_pkg::CMD_DEC_BYTE, 8'hff, 1'b0, 64'sd0, 1'b0, NOT_TYPED});
    add_row({scn_pkg::CMD_DEC_BYTE, 8'h7f, 1'b1, 64'sd0, 1'b1,
             decoded(64'sh7fff_ffff, scn_pkg::ST_OK)});
    // Five bytes against a four-byte limit overflows.
    add_row({scn_pkg::CMD_DEC_BYTE, 8'h01, 1'b0, 64'sd0, 1'b0, NOT_TYPED});
    add_row({scn_pkg::CMD_DEC_BYTE, 8'h01, 1'b0, 64'sd0, 1'b0, NOT_TYPED});
    add_row({scn_pkg::CMD_DEC_BYTE, 8'h01, 1'b0, 64'sd0, 1'b0, NOT_TYPED});
    add_row({scn_pkg::CMD_DEC_BYTE, 8'h01, 1'b0, 64'sd0, 1'b0, NOT_TYPED});
    add_row({scn_pkg::CMD_DEC_BYTE, 8'h01, 1'b1, 64'sd0, 1'b1,
             decoded(64'sd0, scn_pkg::ST_OVERFLOW)});
    // A bare sign byte is redundant unless the byte below needs its top bit.
    add_row({scn_pkg::CMD_DEC_BYTE, 8'h00, 1'b0, 64'sd0, 1'b0, NOT_TYPED});
    add_row({scn_pkg::CMD_DEC_BYTE, 8'h80, 1'b1, 64'sd0, 1'b1,
             decoded(64'sd0, scn_pkg::ST_NONMINIMAL)});
    add_row({scn_pkg::CMD_DEC_BYTE, 8'h80, 1'b0, 64'sd0, 1'b0, NOT_TYPED});
    add_row({scn_pkg::CMD_DEC_BYTE, 8'h80, 1'b1, 64'sd0, 1'b1,
             decoded(-64'sd128, scn_pkg::ST_OK)});
    // Encodes of zero and of both 64-bit extremes.
    add_row({scn_pkg::CMD_ENCODE, 8'h00, 1'b0, 64'sd0, 1'b1, EMPTY_ENCODING});
    add_row({scn_pkg::CMD_ENCODE, 8'hff, 1'b1, 64'sh8000_0000_0000_0000, 1'b0,
             NOT_TYPED});
    add_row({scn_pkg::CMD_ENCODE, 8'h00, 1'b0, 64'sh7fff_ffff_ffff_ffff, 1'b0,
             NOT_TYPED});
    // The unused command is ignored.
    add_row({CMD_UNUSED, 8'haa, 1'b1, 64'sh5555_5555_5555_5555, 1'b0, NOT_TYPED});
    // An empty number in the middle of a run throws the open bytes away.
    add_row({scn_pkg::CMD_DEC_BYTE, 8'h05, 1'b0, 64'sd0, 1'b0, NOT_TYPED});
    add_row({scn_pkg::CMD_DEC_EMPTY, 8'h00, 1'b0, 64'sd0, 1'b1,
             decoded(64'sd0, scn_pkg::ST_OK)});
    // An encode in the middle of a run leaves the open bytes in place.
    add_row({scn_pkg::CMD_DEC_BYTE, 8'h05, 1'b0, 64'sd0, 1'b0, NOT_TYPED});
    add_row({scn_pkg::CMD_ENCODE, 8'h00, 1'b0, 64'sd128, 1'b0, NOT_TYPED});
    add_row({scn_pkg::CMD_DEC_BYTE, 8'h01, 1'b1, 64'sd0, 1'b0, NOT_TYPED});

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      offer(directed_rows[i].item.cmd, directed_rows[i].item.data_byte,
            directed_rows[i].item.last, directed_rows[i].item.value,
            directed_rows[i].typed, directed_rows[i].want);
    end

    // Random phases, each under its own register settings. The first one starts
    // with the long receiver hold-off; the last one runs without any idling.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       begin phase_size = 4'd8;  phase_minimal = 1'b1; end
        1:       begin phase_size = 4'd1;  phase_minimal = 1'b1; end
        2:       begin phase_size = 4'd0;  phase_minimal = 1'b1; end
        3:       begin phase_size = 4'd15; phase_minimal = 1'b0; end
        4:       begin phase_size = 4'd8;  phase_minimal = 1'b0; end
        default: begin phase_size = 4'd4;  phase_minimal = 1'b1; end
      endcase
      write_register(scn_pkg::REG_MAX_SIZE, phase_size);
      write_register(scn_pkg::REG_REQ_MIN, {3'($urandom), phase_minimal});
      if (phase == 0) begin
        hold_request = 1'b1;
      end
      if (phase == 5) begin
        calm = 1'b1;
      end
      phase_start = offered_items;
      while (offered_items - phase_start < PHASE_ITEMS) begin
        random_group();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (number_results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("script_number_codec_top_test: PASS");
    end else begin
      $display("script_number_codec_top_test: FAIL");
    end
    $finish;
  end

endmodule
